[rtl/dsgs_pkg.sv]
// ----------------------------------------------------------------------------
// dsgs_pkg
// Shared constants, register codes and types of the scatter-gather segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsgs_pkg;

    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ADDR_BITS_DEF    = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam int BUS_ADDR_W = 32;
    localparam int LEN_W      = 24;
    localparam int NUM_W      = 6;
    localparam int LIMIT_W    = 7;
    localparam int BOUND_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [BOUND_W-1:0]    RST_BOUNDARY    = '0;
    localparam logic [LEN_W-1:0]      RST_MAX_LEN     = 24'd65536;
    localparam logic [LIMIT_W-1:0]    RST_SEG_LIMIT   = 7'd64;
    localparam logic [BUS_ADDR_W-1:0] RST_ADDR_OFFSET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUNDARY    = 2'd0,
        CFG_MAX_LEN     = 2'd1,
        CFG_SEG_LIMIT   = 2'd2,
        CFG_ADDR_OFFSET = 2'd3
    } cfg_index_t;

    // settings as the chunk engine uses them (clamped, window isolated)
    typedef struct packed {
        logic [LEN_W-1:0]   max_len;
        logic [LIMIT_W-1:0] limit;
        logic [BOUND_W-1:0] window;
    } dsgs_params_t;

endpackage

`default_nettype wire

[rtl/dsgs_if.sv]
// ----------------------------------------------------------------------------
// dsgs_if
// Valid/ready channels for buffer beats and segment beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsgs_buf_if;
    import dsgs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [BUS_ADDR_W-1:0] buffer_address;
    logic [LEN_W-1:0]      buffer_length;
    logic                  first_buffer;
    logic                  final_buffer;

    modport source (
        output valid, buffer_address, buffer_length, first_buffer, final_buffer,
        input  ready
    );
    modport sink (
        input  valid, buffer_address, buffer_length, first_buffer, final_buffer,
        output ready
    );
endinterface

interface dsgs_seg_if;
    import dsgs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [BUS_ADDR_W-1:0] seg_address;
    logic [LEN_W-1:0]      seg_length;
    logic [NUM_W-1:0]      seg_number;
    logic                  last_of_run;
    logic                  too_many_segments;

    modport source (
        output valid, seg_address, seg_length, seg_number, last_of_run,
               too_many_segments,
        input  ready
    );
    modport sink (
        input  valid, seg_address, seg_length, seg_number, last_of_run,
               too_many_segments,
        output ready
    );
endinterface

`default_nettype wire

[rtl/dsgs_front.sv]
// ----------------------------------------------------------------------------
// dsgs_front
// Configuration registers, bus address translation and setting clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module dsgs_front #(
    parameter int MAX_SEGMENTS = dsgs_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = dsgs_pkg::ADDR_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    dsgs_buf_if.sink                             buffers,
    input  wire logic                            cfg_we,
    input  wire logic [dsgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dsgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                                 push_valid,
    input  wire logic                            push_ready,
    output logic [ADDR_BITS-1:0]                 push_addr,
    output logic [dsgs_pkg::LEN_W-1:0]           push_len,
    output logic                                 push_first,
    output logic                                 push_final,
    output dsgs_pkg::dsgs_params_t               params
);
    import dsgs_pkg::*;

    logic [BOUND_W-1:0]    boundary_size_reg;
    logic [LEN_W-1:0]      max_segment_length_reg;
    logic [LIMIT_W-1:0]    segment_limit_reg;
    logic [BUS_ADDR_W-1:0] address_offset_reg;
    logic [63:0]           bus_sum;
    dsgs_params_t          params_next;
    dsgs_params_t          params_reg;

    // isolate the highest set bit
    function automatic logic [BOUND_W-1:0] top_bit(input logic [BOUND_W-1:0] b);
        logic [BOUND_W-1:0] s;
        s = b;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return b & ~(s >> 1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_size_reg      <= RST_BOUNDARY;
            max_segment_length_reg <= RST_MAX_LEN;
            segment_limit_reg      <= RST_SEG_LIMIT;
            address_offset_reg     <= RST_ADDR_OFFSET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BOUNDARY:    boundary_size_reg      <= cfg_wdata[BOUND_W-1:0];
                CFG_MAX_LEN:     max_segment_length_reg <= cfg_wdata[LEN_W-1:0];
                CFG_SEG_LIMIT:   segment_limit_reg      <= cfg_wdata[LIMIT_W-1:0];
                CFG_ADDR_OFFSET: address_offset_reg     <= cfg_wdata[BUS_ADDR_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        params_next.window  = top_bit(boundary_size_reg);
        params_next.max_len = (max_segment_length_reg == '0) ? LEN_W'(1)
                                                             : max_segment_length_reg;
        priority if (segment_limit_reg == '0)
            params_next.limit = LIMIT_W'(1);
        else if (segment_limit_reg > LIMIT_W'(MAX_SEGMENTS))
            params_next.limit = LIMIT_W'(MAX_SEGMENTS);
        else
            params_next.limit = segment_limit_reg;
    end

    always_ff @(posedge clk)
    begin
        params_reg <= params_next;
    end

    assign params = params_reg;

    assign bus_sum    = 64'(buffers.buffer_address) + 64'(address_offset_reg);
    assign push_addr  = bus_sum[ADDR_BITS-1:0];
    assign push_len   = buffers.buffer_length;
    assign push_first = buffers.first_buffer;
    assign push_final = buffers.final_buffer;
    assign push_valid = buffers.valid;
    assign buffers.ready = push_ready;

endmodule

`default_nettype wire

[rtl/dsgs_fifo.sv]
// ----------------------------------------------------------------------------
// dsgs_fifo
// Short register queue between the front and the chunk engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dsgs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dsgs_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

`default_nettype wire

[rtl/dsgs_back.sv]
// ----------------------------------------------------------------------------
// dsgs_back
// Chunk engine: cuts buffers into chunks, merges them into segments and
// drives the segment channel through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsgs_back #(
    parameter int PAGE_BYTES = dsgs_pkg::PAGE_BYTES_DEF,
    parameter int ADDR_BITS  = dsgs_pkg::ADDR_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire logic [ADDR_BITS-1:0]         q_addr,
    input  wire logic [dsgs_pkg::LEN_W-1:0]   q_len,
    input  wire logic                         q_first,
    input  wire logic                         q_final,
    input  wire dsgs_pkg::dsgs_params_t       params,
    dsgs_seg_if.source                        segments
);
    import dsgs_pkg::*;

    localparam int PAGE_W = $clog2(PAGE_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_FLUSH
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_BITS-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]      rem_reg, rem_next;
    logic                  final_reg, final_next;
    logic [ADDR_BITS-1:0]  open_addr_reg, open_addr_next;
    logic [LEN_W-1:0]      open_len_reg, open_len_next;
    logic                  open_valid_reg, open_valid_next;
    logic [NUM_W-1:0]      idx_reg, idx_next;
    logic [ADDR_BITS-1:0]  prev_end_reg, prev_end_next;
    logic                  overflowed_reg, overflowed_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BUS_ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;
    logic [NUM_W-1:0]      out_num_reg, out_num_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_err_reg, out_err_next;

    logic [PAGE_W:0]       page_room;
    logic [63:0]           cur64;
    logic [63:0]           open64;
    logic [63:0]           wlow64;
    logic [BOUND_W-1:0]    to_edge;
    logic [LEN_W-1:0]      sg_page;
    logic [LEN_W-1:0]      sg_max;
    logic [LEN_W-1:0]      sg_rem;
    logic [LEN_W-1:0]      sg;
    logic [LEN_W:0]        len_sum;
    logic [ADDR_BITS-1:0]  wmask;
    logic                  window_ok;
    logic                  merge;
    logic [NUM_W:0]        next_idx;
    logic                  out_free;
    logic [ADDR_BITS-1:0]  cur_adv;

    // chunk size, merge test and output-register state
    always_comb
    begin
        cur64     = 64'(cur_reg);
        open64    = 64'(open_addr_reg);
        page_room = (PAGE_W + 1)'(PAGE_BYTES) - {1'b0, cur_reg[PAGE_W-1:0]};
        sg_page   = LEN_W'(page_room);
        sg_max    = (params.max_len < sg_page) ? params.max_len : sg_page;
        sg_rem    = (rem_reg < sg_max) ? rem_reg : sg_max;
        to_edge   = params.window - (cur64[BOUND_W-1:0] & (params.window - BOUND_W'(1)));
        if ((params.window != '0) && (to_edge < BOUND_W'(sg_rem)))
            sg = to_edge[LEN_W-1:0];
        else
            sg = sg_rem;
        wlow64    = {32'b0, params.window - BOUND_W'(1)};
        wmask     = ~wlow64[ADDR_BITS-1:0];
        window_ok = (params.window == '0) || (((open_addr_reg ^ cur_reg) & wmask) == '0);
        len_sum   = {1'b0, open_len_reg} + {1'b0, sg};
        merge     = open_valid_reg && (cur_reg == prev_end_reg) &&
                    (len_sum <= {1'b0, params.max_len}) && window_ok;
        next_idx  = {1'b0, idx_reg} + (NUM_W + 1)'(1);
        cur_adv   = cur_reg + ADDR_BITS'(sg);
        out_free  = !out_valid_reg || segments.ready;
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        final_next      = final_reg;
        open_addr_next  = open_addr_reg;
        open_len_next   = open_len_reg;
        open_valid_next = open_valid_reg;
        idx_next        = idx_reg;
        prev_end_next   = prev_end_reg;
        overflowed_next = overflowed_reg;
        out_valid_next  = out_valid_reg && !segments.ready;
        out_addr_next   = out_addr_reg;
        out_len_next    = out_len_reg;
        out_num_next    = out_num_reg;
        out_last_next   = out_last_reg;
        out_err_next    = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next   = q_addr;
                    rem_next   = q_len;
                    final_next = q_final;
                    state_next = ST_CHUNK;
                    if (q_first)
                    begin
                        open_addr_next  = '0;
                        open_len_next   = '0;
                        open_valid_next = 1'b0;
                        idx_next        = '0;
                        prev_end_next   = '0;
                        overflowed_next = 1'b0;
                    end
                end
            end
            ST_CHUNK:
            begin
                priority if (overflowed_reg)
                    state_next = ST_IDLE;
                else if (rem_reg == '0)
                    state_next = final_reg ? ST_FLUSH : ST_IDLE;
                else if (merge)
                begin
                    open_len_next = len_sum[LEN_W-1:0];
                    cur_next      = cur_adv;
                    prev_end_next = cur_adv;
                    rem_next      = rem_reg - sg;
                end
                else if (open_valid_reg && (next_idx >= {1'b0, params.limit}))
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_addr_next   = '0;
                        out_len_next    = '0;
                        out_num_next    = '0;
                        out_last_next   = 1'b1;
                        out_err_next    = 1'b1;
                        open_valid_next = 1'b0;
                        open_len_next   = '0;
                        open_addr_next  = '0;
                        overflowed_next = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (open_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_addr_next  = open64[BUS_ADDR_W-1:0];
                        out_len_next   = open_len_reg;
                        out_num_next   = idx_reg;
                        out_last_next  = 1'b0;
                        out_err_next   = 1'b0;
                        idx_next       = next_idx[NUM_W-1:0];
                        open_addr_next = cur_reg;
                        open_len_next  = sg;
                        cur_next       = cur_adv;
                        prev_end_next  = cur_adv;
                        rem_next       = rem_reg - sg;
                    end
                end
                else
                begin
                    open_addr_next  = cur_reg;
                    open_len_next   = sg;
                    open_valid_next = 1'b1;
                    cur_next        = cur_adv;
                    prev_end_next   = cur_adv;
                    rem_next        = rem_reg - sg;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = open_valid_reg ? open64[BUS_ADDR_W-1:0] : '0;
                    out_len_next    = open_valid_reg ? open_len_reg : '0;
                    out_num_next    = idx_reg;
                    out_last_next   = 1'b1;
                    out_err_next    = 1'b0;
                    open_valid_next = 1'b0;
                    open_addr_next  = '0;
                    open_len_next   = '0;
                    idx_next        = '0;
                    prev_end_next   = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            rem_reg        <= '0;
            final_reg      <= 1'b0;
            open_addr_reg  <= '0;
            open_len_reg   <= '0;
            open_valid_reg <= 1'b0;
            idx_reg        <= '0;
            prev_end_reg   <= '0;
            overflowed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_len_reg    <= '0;
            out_num_reg    <= '0;
            out_last_reg   <= 1'b0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            rem_reg        <= rem_next;
            final_reg      <= final_next;
            open_addr_reg  <= open_addr_next;
            open_len_reg   <= open_len_next;
            open_valid_reg <= open_valid_next;
            idx_reg        <= idx_next;
            prev_end_reg   <= prev_end_next;
            overflowed_reg <= overflowed_next;
            out_valid_reg  <= out_valid_next;
            out_addr_reg   <= out_addr_next;
            out_len_reg    <= out_len_next;
            out_num_reg    <= out_num_next;
            out_last_reg   <= out_last_next;
            out_err_reg    <= out_err_next;
        end
    end

    assign q_ready                    = (state_reg == ST_IDLE);
    assign segments.valid             = out_valid_reg;
    assign segments.seg_address       = out_addr_reg;
    assign segments.seg_length        = out_len_reg;
    assign segments.seg_number        = out_num_reg;
    assign segments.last_of_run       = out_last_reg;
    assign segments.too_many_segments = out_err_reg;

`ifndef SYNTH
    // an overflow beat closes the mapping and carries no segment
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_last_reg && (out_len_reg == '0))
        else $error("overflow beat malformed");

    a_ovf_closed: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> !open_valid_reg)
        else $error("segment open after overflow");

    a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
        open_valid_reg |-> (open_len_reg != '0))
        else $error("open segment with zero length");
`endif

endmodule

`default_nettype wire

[rtl/dma_scatter_gather_segmenter.sv]
// ----------------------------------------------------------------------------
// dma_scatter_gather_segmenter
// Translates buffers to bus addresses and builds a scatter-gather list.
// ----------------------------------------------------------------------------
// A buffer beat is queued by the front in the cycle it arrives; the chunk
// engine then takes it from the queue and cuts it into chunks, one chunk
// per cycle unless a segment waits on the output register (a chunk ends at
// a page end, the maximum segment length or a boundary window end), then
// emits a closing beat for a final buffer. Emitting a segment waits while
// the output register still holds an untaken beat. The two-entry queue
// lets buffer beats arrive while the engine works. Settings are to be
// written only while the block is idle; the block does not enforce this.
`default_nettype none

module dma_scatter_gather_segmenter #(
    parameter int PAGE_BYTES   = dsgs_pkg::PAGE_BYTES_DEF,
    parameter int MAX_SEGMENTS = dsgs_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = dsgs_pkg::ADDR_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    dsgs_buf_if.sink                             buffers,
    dsgs_seg_if.source                           segments,
    input  wire logic                            cfg_we,
    input  wire logic [dsgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dsgs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dsgs_pkg::*;

    localparam int ENTRY_W = ADDR_BITS + LEN_W + 2;

    logic                 push_valid;
    logic                 push_ready;
    logic [ADDR_BITS-1:0] push_addr;
    logic [LEN_W-1:0]     push_len;
    logic                 push_first;
    logic                 push_final;
    logic                 q_valid;
    logic                 q_ready;
    logic [ENTRY_W-1:0]   q_data;
    dsgs_params_t         params;

    dsgs_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .buffers    (buffers),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_addr  (push_addr),
        .push_len   (push_len),
        .push_first (push_first),
        .push_final (push_final),
        .params     (params)
    );

    dsgs_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_addr, push_len, push_first, push_final}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    dsgs_back #(
        .PAGE_BYTES (PAGE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_addr   (q_data[ENTRY_W-1 -: ADDR_BITS]),
        .q_len    (q_data[LEN_W+1:2]),
        .q_first  (q_data[1]),
        .q_final  (q_data[0]),
        .params   (params),
        .segments (segments)
    );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scatter-gather segmenter: a table of directed
// buffers and register writes, then random mappings under several settings.
// Segment beats are checked against the table or an in-bench chunking model.
// ----------------------------------------------------------------------------
module tb;
    import dsgs_pkg::*;

    localparam int PAGE        = PAGE_BYTES_DEF;
    localparam int SEG_MAX     = MAX_SEGMENTS_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 30;
    localparam int N_ROWS      = 28;

    typedef struct packed {
        logic [BUS_ADDR_W-1:0] seg_address;
        logic [LEN_W-1:0]      seg_length;
        logic [NUM_W-1:0]      seg_number;
        logic                  last_of_run;
        logic                  too_many_segments;
    } seg_beat_t;

    typedef enum logic {ROW_BUF, ROW_CFG} row_kind_t;

    // value is the buffer address on buffer rows, the write data on register rows
    typedef struct packed {
        row_kind_t        kind;
        cfg_index_t       reg_sel;
        logic [31:0]      value;
        logic [LEN_W-1:0] length;
        logic             opens_map;
        logic             final_buf;
        logic             typed;
        seg_beat_t        want;
    } stim_row_t;

    localparam seg_beat_t NO_BEAT = '0;

    stim_row_t stim_rows [N_ROWS] = '{
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_1000, 24'h000100, 1'b1, 1'b1, 1'b1,
          '{32'h0000_1000, 24'h000100, 6'd0, 1'b1, 1'b0}},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0000, 24'h000000, 1'b1, 1'b1, 1'b1,
          '{32'h0000_0000, 24'h000000, 6'd0, 1'b1, 1'b0}},
        '{ROW_BUF, CFG_BOUNDARY,    32'hFFFF_FF00, 24'h000100, 1'b1, 1'b1, 1'b1,
          '{32'hFFFF_FF00, 24'h000100, 6'd0, 1'b1, 1'b0}},
        '{ROW_BUF, CFG_BOUNDARY,    32'hFFFF_FF80, 24'h000100, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0800, 24'h002000, 1'b1, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_2800, 24'h000100, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0010_0000, 24'h000010, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0000, 24'h000000, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0000, 24'hFFFFFF, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h1234_5678, 24'h000020, 1'b0, 1'b1, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_SEG_LIMIT,   32'h0000_0001, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0040, 24'h000010, 1'b1, 1'b1, 1'b1,
          '{32'h0000_0040, 24'h000010, 6'd0, 1'b1, 1'b0}},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0FF0, 24'h000020, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0100, 24'h000010, 1'b1, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0300, 24'h000010, 1'b0, 1'b1, 1'b1,
          '{32'h0000_0000, 24'h000000, 6'd0, 1'b1, 1'b1}},
        '{ROW_CFG, CFG_SEG_LIMIT,   32'h0000_0000, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_MAX_LEN,     32'h0000_0000, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0007, 24'h000003, 1'b1, 1'b1, 1'b1,
          '{32'h0000_0000, 24'h000000, 6'd0, 1'b1, 1'b1}},
        '{ROW_CFG, CFG_SEG_LIMIT,   32'h0000_007F, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_MAX_LEN,     32'h00FF_FFFF, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_BOUNDARY,    32'h0000_0001, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_0010, 24'h000003, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_BOUNDARY,    32'h8000_0000, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_ADDR_OFFSET, 32'hFFFF_FFFF, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h7FFF_F001, 24'h003000, 1'b1, 1'b1, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_BOUNDARY,    32'h0000_3000, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_ADDR_OFFSET, 32'h0000_0010, 24'h000000, 1'b0, 1'b0, 1'b0, NO_BEAT},
        '{ROW_BUF, CFG_BOUNDARY,    32'h0000_1EF0, 24'h000400, 1'b1, 1'b1, 1'b0, NO_BEAT}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dsgs_buf_if buffers_ch ();
    dsgs_seg_if segments_ch ();

    dma_scatter_gather_segmenter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .buffers   (buffers_ch),
        .segments  (segments_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // register copies
    logic [BOUND_W-1:0]    cfg_boundary;
    logic [LEN_W-1:0]      cfg_max_len;
    logic [LIMIT_W-1:0]    cfg_seg_limit;
    logic [BUS_ADDR_W-1:0] cfg_offset;

    // mapping state
    logic [BUS_ADDR_W-1:0] open_addr;
    logic [LEN_W-1:0]      open_len;
    bit                    open_valid;
    logic [LIMIT_W-1:0]    seg_index;
    logic [BUS_ADDR_W-1:0] prev_end;
    bit                    overflowed;

    seg_beat_t segments_due [$];
    seg_beat_t step_segments [$];
    int        step_chunks;
    int        pending_work;
    int        errors;
    bit        calm;
    bit        hold_request;
    bit        hold_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(50_000_000);
        $display("status: fail");
        $finish;
    end

    function automatic void segment_buffer(input logic [31:0] addr,
                                           input logic [LEN_W-1:0] len,
                                           input logic first_b,
                                           input logic final_b);
        logic [31:0]     cur;
        logic [31:0]     win;
        logic [31:0]     wmask;
        logic [31:0]     next_end;
        longint unsigned remaining;
        longint unsigned sg;
        longint unsigned to_edge;
        longint unsigned maxlen;
        longint unsigned limit;
        bit              alive;
        int              i;

        cur       = addr + cfg_offset;
        remaining = len;
        maxlen    = (cfg_max_len == 0) ? 1 : cfg_max_len;
        if (cfg_seg_limit == 0)
            limit = 1;
        else if (cfg_seg_limit > SEG_MAX)
            limit = SEG_MAX;
        else
            limit = cfg_seg_limit;
        win = '0;
        for (i = 0; i < BOUND_W; i++)
            if (cfg_boundary[i])
                win = 32'd1 << i;
        wmask = ~(win - 32'd1);
        step_segments.delete();
        step_chunks = 0;

        if (first_b)
        begin
            open_addr  = '0;
            open_len   = '0;
            open_valid = 1'b0;
            seg_index  = '0;
            prev_end   = '0;
            overflowed = 1'b0;
        end
        alive = !overflowed;

        // chunks are walked to the end even after an overflow, to bound the work
        while (remaining != 0)
        begin
            sg = PAGE - (cur & 32'(PAGE - 1));
            if (sg > maxlen)
                sg = maxlen;
            if (sg > remaining)
                sg = remaining;
            if (win != 0)
            begin
                to_edge = win - (cur & (win - 32'd1));
                if (sg > to_edge)
                    sg = to_edge;
            end
            step_chunks++;
            next_end = cur + sg[31:0];

            if (alive)
            begin
                if (open_valid && cur == prev_end && open_len + sg <= maxlen &&
                    (win == 0 || (open_addr & wmask) == (cur & wmask)))
                    open_len = open_len + sg[LEN_W-1:0];
                else
                begin
                    if (open_valid)
                    begin
                        if (seg_index + 1 >= limit)
                        begin
                            step_segments.push_back('{32'h0, 24'h0, 6'd0, 1'b1, 1'b1});
                            open_valid = 1'b0;
                            open_addr  = '0;
                            open_len   = '0;
                            overflowed = 1'b1;
                            alive      = 1'b0;
                        end
                        else
                        begin
                            step_segments.push_back('{open_addr, open_len,
                                                      seg_index[NUM_W-1:0], 1'b0, 1'b0});
                            seg_index = seg_index + LIMIT_W'(1);
                        end
                    end
                    if (alive)
                    begin
                        open_addr  = cur;
                        open_len   = sg[LEN_W-1:0];
                        open_valid = 1'b1;
                    end
                end
                if (alive)
                    prev_end = next_end;
            end
            cur = next_end;
            remaining -= sg;
        end

        if (final_b && alive)
        begin
            step_segments.push_back('{open_valid ? open_addr : 32'h0,
                                      open_valid ? open_len : 24'h0,
                                      seg_index[NUM_W-1:0], 1'b1, 1'b0});
            open_valid = 1'b0;
            open_addr  = '0;
            open_len   = '0;
            seg_index  = '0;
            prev_end   = '0;
        end
    endfunction

    task automatic send_buffer(input logic [31:0] addr, input logic [LEN_W-1:0] len,
                               input logic first_b, input logic final_b,
                               input logic typed, input seg_beat_t want);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            buffers_ch.valid <= 1'b0;
            @(posedge clk);
        end
        buffers_ch.valid          <= 1'b1;
        buffers_ch.buffer_address <= addr;
        buffers_ch.buffer_length  <= len;
        buffers_ch.first_buffer   <= first_b;
        buffers_ch.final_buffer   <= final_b;
        @(posedge clk);
        while (!buffers_ch.ready)
            @(posedge clk);
        segment_buffer(addr, len, first_b, final_b);
        pending_work += 4 + step_chunks;
        if (typed)
            segments_due.push_back(want);
        else
            foreach (step_segments[j])
                segments_due.push_back(step_segments[j]);
    endtask

    // block idle: all beats back, then room for buffers that give no beat
    task automatic settle();
        buffers_ch.valid <= 1'b0;
        while (segments_due.size() != 0)
            @(posedge clk);
        repeat (pending_work + 8) @(posedge clk);
        pending_work = 0;
    endtask

    task automatic write_setting(input cfg_index_t sel, input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (sel)
            CFG_BOUNDARY:    cfg_boundary  = v;
            CFG_MAX_LEN:     cfg_max_len   = v[LEN_W-1:0];
            CFG_SEG_LIMIT:   cfg_seg_limit = v[LIMIT_W-1:0];
            CFG_ADDR_OFFSET: cfg_offset    = v;
            default: ;
        endcase
    endtask

    initial
    begin
        segments_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                segments_ch.ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            segments_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge clk)
    begin : seg_check
        seg_beat_t got;
        seg_beat_t want;
        if (rst_n && segments_ch.valid && segments_ch.ready)
        begin
            got = '{segments_ch.seg_address, segments_ch.seg_length,
                    segments_ch.seg_number, segments_ch.last_of_run,
                    segments_ch.too_many_segments};
            if (segments_due.size() == 0)
            begin
                $error("segment beat with none expected: address %0h length %0h",
                       got.seg_address, got.seg_length);
                errors++;
            end
            else
            begin
                want = segments_due.pop_front();
                if (got.seg_address != want.seg_address)
                begin
                    $error("seg_address: expected %0h, actual %0h",
                           want.seg_address, got.seg_address);
                    errors++;
                end
                if (got.seg_length != want.seg_length)
                begin
                    $error("seg_length: expected %0h, actual %0h",
                           want.seg_length, got.seg_length);
                    errors++;
                end
                if (got.seg_number != want.seg_number)
                begin
                    $error("seg_number: expected %0d, actual %0d",
                           want.seg_number, got.seg_number);
                    errors++;
                end
                if (got.last_of_run != want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, actual %0b",
                           want.last_of_run, got.last_of_run);
                    errors++;
                end
                if (got.too_many_segments != want.too_many_segments)
                begin
                    $error("too_many_segments: expected %0b, actual %0b",
                           want.too_many_segments, got.too_many_segments);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int              ph;
        int              n;
        int              k;
        int              r;
        int              phase_items;
        logic [31:0]     b_val;
        logic [31:0]     m_val;
        logic [31:0]     l_val;
        logic [31:0]     o_val;
        logic [31:0]     addr;
        logic [31:0]     next_addr;
        logic [LEN_W-1:0] len;
        logic            first_b;
        logic            final_b;
        longint unsigned eff_max;

        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= '0;
        cfg_wdata                 <= '0;
        buffers_ch.valid          <= 1'b0;
        buffers_ch.buffer_address <= '0;
        buffers_ch.buffer_length  <= '0;
        buffers_ch.first_buffer   <= 1'b0;
        buffers_ch.final_buffer   <= 1'b0;
        errors       = 0;
        pending_work = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        cfg_boundary  = RST_BOUNDARY;
        cfg_max_len   = RST_MAX_LEN;
        cfg_seg_limit = RST_SEG_LIMIT;
        cfg_offset    = RST_ADDR_OFFSET;
        open_addr     = '0;
        open_len      = '0;
        open_valid    = 1'b0;
        seg_index     = '0;
        prev_end      = '0;
        overflowed    = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (stim_rows[i].kind == ROW_CFG)
            begin
                settle();
                write_setting(stim_rows[i].reg_sel, stim_rows[i].value);
            end
            else
                send_buffer(stim_rows[i].value, stim_rows[i].length,
                            stim_rows[i].opens_map, stim_rows[i].final_buf,
                            stim_rows[i].typed, stim_rows[i].want);
        end

        for (ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    b_val = RST_BOUNDARY;
                    m_val = RST_MAX_LEN;
                    l_val = RST_SEG_LIMIT;
                    o_val = RST_ADDR_OFFSET;
                end
                1:
                begin
                    b_val = 32'h0000_1000;
                    m_val = 32'h0000_0800;
                    l_val = 32'd8;
                    o_val = $urandom;
                end
                2:
                begin
                    b_val = 32'd1 << $urandom_range(8, 16);
                    m_val = $urandom_range(1, 32'h4000);
                    l_val = $urandom_range(1, 8);
                    o_val = $urandom;
                end
                3:
                begin
                    b_val = $urandom | 32'h0000_0100;
                    m_val = 32'h00FF_FFFF;
                    l_val = $urandom_range(0, 127);
                    o_val = $urandom;
                end
                default:
                begin
                    b_val = 32'h0;
                    m_val = $urandom_range(0, 16);
                    l_val = 32'd64;
                    o_val = 32'hFFFF_FFFF;
                end
            endcase
            write_setting(CFG_BOUNDARY, b_val);
            write_setting(CFG_MAX_LEN, m_val);
            write_setting(CFG_SEG_LIMIT, l_val);
            write_setting(CFG_ADDR_OFFSET, o_val);
            eff_max = (cfg_max_len == 0) ? 1 : cfg_max_len;
            calm = (ph == 1);
            phase_items = 0;

            while (phase_items < PHASE_ITEMS)
            begin
                n = $urandom_range(1, 6);
                next_addr = $urandom;
                for (k = 0; k < n && phase_items < PHASE_ITEMS; k++)
                begin
                    if (ph == 2 && phase_items == 4)
                        hold_request = 1'b1;
                    if (k > 0 && $urandom_range(0, 99) < 60)
                        addr = next_addr;
                    else
                    begin
                        addr = $urandom;
                        if ($urandom_range(0, 3) == 0)
                            addr[11:0] = 12'hF00 | 12'($urandom_range(0, 255));
                    end
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        len = '0;
                    else if (r < 70)
                        len = LEN_W'($urandom_range(1, 32'h1800));
                    else if (r < 93)
                        len = LEN_W'($urandom_range(1, 32'h10000));
                    else
                        len = LEN_W'($urandom_range(1, 32'h40000));
                    if (eff_max < 256)
                        len = LEN_W'(len % 600);
                    first_b = (k == 0) ? ($urandom_range(0, 99) < 92)
                                       : ($urandom_range(0, 99) < 4);
                    final_b = (k == n - 1) ? ($urandom_range(0, 99) < 92)
                                           : ($urandom_range(0, 99) < 4);
                    send_buffer(addr, len, first_b, final_b, 1'b0, NO_BEAT);
                    next_addr = addr + len;
                    phase_items++;
                end
            end
        end

        calm = 1'b0;
        settle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
